FILE: sv/fdmd_pkg.sv
// Shared types and constants of the frame difference motion detector.
package fdmd_pkg;

	// Sample store geometry.
	localparam int MAX_SAMPLES = 8192;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

	// Division datapath widths: the quotient never exceeds 100.
	localparam int QUO_W = 7;
	localparam int NUM_W = CNT_W + QUO_W;

	// Item opcodes.
	localparam logic [1:0] OP_REF  = 2'd0;
	localparam logic [1:0] OP_CMP  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SAMPLE_STEP = 2'd0;
	localparam logic [1:0] CFG_DIFF_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD   = 2'd2;
	localparam logic [1:0] CFG_COOLDOWN    = 2'd3;

	// Configuration reset values.
	localparam logic [7:0]  RST_SAMPLE_STEP = 8'd10;
	localparam logic [7:0]  RST_DIFF_LIMIT  = 8'd20;
	localparam logic [6:0]  RST_THRESHOLD   = 7'd30;
	localparam logic [15:0] RST_COOLDOWN    = 16'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_DIV_LOAD,
		ST_DIV,
		ST_FIN
	} fdmd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic compare;
		logic div_load;
		logic div_step;
		logic finish;
	} fdmd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cmp_read;
		logic cmp_last;
		logic div_last;
		logic out_free;
	} fdmd_status_t;

endpackage

FILE: sv/fdmd_in_if.sv
// Input channel interface: one frame byte or tick per word.
interface fdmd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output opcode, output data_byte, output last_byte,
		input ready);
	modport sink (input valid, input opcode, input data_byte, input last_byte,
		output ready);
endinterface

FILE: sv/fdmd_out_if.sv
// Output channel interface: one detection report per word.
interface fdmd_out_if;
	logic        valid;
	logic        ready;
	logic        motion;
	logic        trigger;
	logic [6:0]  percent;
	logic [13:0] changed_count;
	logic [13:0] compared_count;

	modport source (output valid, output motion, output trigger, output percent,
		output changed_count, output compared_count, input ready);
	modport sink (input valid, input motion, input trigger, input percent,
		input changed_count, input compared_count, output ready);
endinterface

FILE: sv/fdmd_ctrl.sv
// Controller state machine of the frame difference motion detector.
module fdmd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fdmd_pkg::fdmd_status_t st,
	output fdmd_pkg::fdmd_cmd_t    cmd
);
	import fdmd_pkg::*;

	fdmd_state_t state_q, state_d;
	logic        last_q;

	// State and pending end-of-frame flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				last_q <= st.cmp_last;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (st.cmp_read) begin
						state_d = ST_CMP;
					end else if (st.cmp_last) begin
						state_d = ST_DIV_LOAD;
					end
				end
			end
			ST_CMP: begin
				state_d = last_q ? ST_DIV_LOAD : ST_IDLE;
			end
			ST_DIV_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (st.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.compare  = (state_q == ST_CMP);
		cmd.div_load = (state_q == ST_DIV_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN) && st.out_free;
	end

endmodule

FILE: sv/fdmd_datapath.sv
// Datapath: configuration, sample store, counters, divider, cooldown and output register.
module fdmd_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic [1:0]             opcode,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  fdmd_pkg::fdmd_cmd_t    cmd,
	output fdmd_pkg::fdmd_status_t st,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   motion,
	output logic                   trigger,
	output logic [6:0]             percent,
	output logic [13:0]            changed_count,
	output logic [13:0]            compared_count
);
	import fdmd_pkg::*;

	// Configuration registers.
	logic [7:0]  sample_step_q;
	logic [7:0]  diff_limit_q;
	logic [6:0]  threshold_q;
	logic [15:0] cooldown_secs_q;

	// Frame state.
	logic [CNT_W-1:0] ref_count_q;
	logic [CNT_W-1:0] cmp_index_q;
	logic [CNT_W-1:0] changed_q;
	logic [7:0]       phase_q;
	logic             restart_q;
	logic             cool_active_q;
	logic [15:0]      cool_elapsed_q;

	// Sample store.
	logic [7:0] store [MAX_SAMPLES];
	logic [7:0] kept_q;

	// Divider.
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [2:0]       div_cnt_q;
	logic             den_zero_q;

	// Output register.
	logic             out_valid_q;
	logic             motion_q;
	logic             trigger_q;
	logic [6:0]       percent_q;
	logic [CNT_W-1:0] changed_out_q;
	logic [CNT_W-1:0] compared_out_q;
	logic [CNT_W-1:0] changed_den_q;
	logic [CNT_W-1:0] compared_den_q;

	// Stride phase: a reference frame restart sees phase zero.
	logic [7:0]       step_eff;
	logic [7:0]       phase_base;
	logic [8:0]       phase_inc;
	logic [7:0]       phase_next;
	logic             sampled;
	logic [CNT_W-1:0] ref_base;
	logic             ref_write;

	always_comb begin
		step_eff   = (sample_step_q == 8'd0) ? 8'd1 : sample_step_q;
		phase_base = (opcode == OP_REF && restart_q) ? 8'd0 : phase_q;
		phase_inc  = {1'b0, phase_base} + 9'd1;
		phase_next = (phase_inc >= {1'b0, step_eff}) ? 8'd0 : phase_inc[7:0];
		sampled    = (phase_base == 8'd0);
		ref_base   = restart_q ? '0 : ref_count_q;
		ref_write  = cmd.accept && (opcode == OP_REF) && sampled
			&& (ref_base < CNT_W'(MAX_SAMPLES));
	end

	// Status toward the controller.
	always_comb begin
		st.cmp_read = (opcode == OP_CMP) && sampled && (cmp_index_q < ref_count_q);
		st.cmp_last = (opcode == OP_CMP) && last_byte;
		st.div_last = (div_cnt_q == 3'd0);
		st.out_free = !out_valid_q || out_ready;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_step_q   <= RST_SAMPLE_STEP;
			diff_limit_q    <= RST_DIFF_LIMIT;
			threshold_q     <= RST_THRESHOLD;
			cooldown_secs_q <= RST_COOLDOWN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_STEP: sample_step_q   <= cfg_data[7:0];
				CFG_DIFF_LIMIT:  diff_limit_q    <= cfg_data[7:0];
				CFG_THRESHOLD:   threshold_q     <= cfg_data[6:0];
				CFG_COOLDOWN:    cooldown_secs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample store: written on sampled reference bytes, read for sampled comparison bytes.
	always_ff @(posedge clk) begin
		if (ref_write) begin
			store[ref_base[ADDR_W-1:0]] <= data_byte;
		end
		if (cmd.accept && st.cmp_read) begin
			kept_q <= store[cmp_index_q[ADDR_W-1:0]];
		end
	end

	// Absolute difference of the kept sample and the incoming byte.
	logic [7:0] abs_diff;
	logic [7:0] byte_hold_q;

	always_comb begin
		abs_diff = (kept_q > byte_hold_q) ? (kept_q - byte_hold_q) : (byte_hold_q - kept_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_hold_q <= data_byte;
		end
	end

	// Cooldown decision for the report being finished.
	logic        motion_n;
	logic        trigger_n;
	logic        active_n;
	logic [15:0] elapsed_n;
	logic [6:0]  percent_n;

	always_comb begin
		percent_n = den_zero_q ? 7'd0 : quo_q;
		motion_n  = (percent_n >= threshold_q);
		trigger_n = motion_n && !cool_active_q;
		active_n  = cool_active_q || trigger_n;
		elapsed_n = trigger_n ? 16'd0 : cool_elapsed_q;
		if (active_n && (elapsed_n >= cooldown_secs_q)) begin
			active_n = 1'b0;
		end
	end

	// Frame counters, stride phase and cooldown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q    <= '0;
			cmp_index_q    <= '0;
			changed_q      <= '0;
			phase_q        <= 8'd0;
			restart_q      <= 1'b1;
			cool_active_q  <= 1'b0;
			cool_elapsed_q <= 16'd0;
		end else begin
			if (cmd.accept) begin
				case (opcode)
					OP_REF: begin
						if (restart_q) begin
							cmp_index_q <= '0;
							changed_q   <= '0;
						end
						ref_count_q <= ref_write ? (ref_base + CNT_W'(1)) : ref_base;
						restart_q   <= last_byte;
						phase_q     <= last_byte ? 8'd0 : phase_next;
					end
					OP_CMP: begin
						phase_q <= last_byte ? 8'd0 : phase_next;
					end
					OP_TICK: begin
						if (cool_active_q && (cool_elapsed_q != 16'hFFFF)) begin
							cool_elapsed_q <= cool_elapsed_q + 16'd1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.compare) begin
				cmp_index_q <= cmp_index_q + CNT_W'(1);
				if (abs_diff > diff_limit_q) begin
					changed_q <= changed_q + CNT_W'(1);
				end
			end
			if (cmd.div_load) begin
				cmp_index_q <= '0;
				changed_q   <= '0;
			end
			if (cmd.finish) begin
				cool_active_q  <= active_n;
				cool_elapsed_q <= elapsed_n;
			end
		end
	end

	// Restoring divider: changed*100 / compared, one quotient bit per step.
	logic [NUM_W-1:0] num_scaled;

	always_comb begin
		num_scaled = (NUM_W'(changed_q) << 6) + (NUM_W'(changed_q) << 5)
			+ (NUM_W'(changed_q) << 2);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q          <= num_scaled;
			dsh_q          <= NUM_W'(cmp_index_q) << (QUO_W - 1);
			quo_q          <= '0;
			div_cnt_q      <= 3'(QUO_W - 1);
			den_zero_q     <= (cmp_index_q == '0);
			changed_den_q  <= changed_q;
			compared_den_q <= cmp_index_q;
		end else if (cmd.div_step) begin
			if (num_q >= dsh_q) begin
				num_q <= num_q - dsh_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsh_q     <= dsh_q >> 1;
			div_cnt_q <= div_cnt_q - 3'd1;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			motion_q       <= motion_n;
			trigger_q      <= trigger_n;
			percent_q      <= percent_n;
			changed_out_q  <= changed_den_q;
			compared_out_q <= compared_den_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign motion         = motion_q;
	assign trigger        = trigger_q;
	assign percent        = percent_q;
	assign changed_count  = changed_out_q;
	assign compared_count = compared_out_q;

endmodule

FILE: sv/frame_difference_motion_detector_unit.sv
// Top level of the frame difference motion detector.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    opcode, data_byte, last_byte
//   out_ch    out   valid/ready    motion, trigger, percent, changed_count, compared_count
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// Reference bytes, ticks and unsampled comparison bytes are accepted back to back.
// A sampled comparison byte also passes through the compare state, as the store read port is registered.
// The last comparison byte adds the divider load, seven divider steps and the finish.
// The finish waits while a previous report still sits in the output register.
// Reset arst_n is asynchronous; the sample store is not cleared and needs no sweep.
module frame_difference_motion_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	fdmd_in_if.sink     in_ch,
	fdmd_out_if.source  out_ch
);
	import fdmd_pkg::*;

	fdmd_cmd_t    cmd;
	fdmd_status_t st;

	fdmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	fdmd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (in_ch.opcode),
		.data_byte      (in_ch.data_byte),
		.last_byte      (in_ch.last_byte),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.motion         (out_ch.motion),
		.trigger        (out_ch.trigger),
		.percent        (out_ch.percent),
		.changed_count  (out_ch.changed_count),
		.compared_count (out_ch.compared_count)
	);

	// A report never shows more than 100 percent.
	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.percent <= 7'd100))
		else $error("percent above 100");

	// A trigger always comes with motion.
	a_trigger_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.trigger) |-> out_ch.motion)
		else $error("trigger without motion");

	// Changed samples never outnumber compared samples.
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.changed_count <= out_ch.compared_count))
		else $error("changed count above compared count");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the frame difference motion detector unit.
`timescale 1ns / 100ps

module tb_top;
	import fdmd_pkg::*;

	// The opcode value that the block ignores.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 60;
	localparam int RANDOM_ITEMS   = 340;

	typedef struct packed {
		logic        motion;
		logic        trigger;
		logic [6:0]  percent;
		logic [13:0] changed;
		logic [13:0] compared;
	} detection_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       last;
		logic       typed;
		detection_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	fdmd_in_if  in_ch ();
	fdmd_out_if out_ch ();

	frame_difference_motion_detector_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Predicted state of the detector and its register copies.
	logic [7:0]  kept_samples [MAX_SAMPLES];
	int unsigned kept_count = 0;
	int unsigned stride_pos = 0;
	int unsigned cmp_count  = 0;
	int unsigned diff_count = 0;
	bit          cooling    = 1'b0;
	int unsigned cool_secs  = 0;
	bit          new_ref    = 1'b1;
	logic [7:0]  stride_cfg = RST_SAMPLE_STEP;
	logic [7:0]  delta_cfg  = RST_DIFF_LIMIT;
	logic [6:0]  thr_cfg    = RST_THRESHOLD;
	logic [15:0] cool_cfg   = RST_COOLDOWN;

	detection_t  pending_reports [$];
	detection_t  oldest_report;
	int unsigned items_sent  = 0;
	int unsigned bad_fields  = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct    = 0;
	int unsigned hold_left    = 0;
	bit          hold_req     = 1'b0;

	// Directed words under the reset configuration.
	stim_row_t reset_rows [$] = '{
		'{OP_CMP,   8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0,   14'd0, 14'd0}},
		'{OP_SPARE, 8'hAA, 1'b1, 1'b0, '0},
		'{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
		'{OP_REF,   8'h00, 1'b0, 1'b0, '0},
		'{OP_REF,   8'hFF, 1'b1, 1'b0, '0},
		'{OP_CMP,   8'h14, 1'b1, 1'b1, '{1'b0, 1'b0, 7'd0,   14'd0, 14'd1}},
		'{OP_CMP,   8'h15, 1'b1, 1'b1, '{1'b1, 1'b1, 7'd100, 14'd1, 14'd1}},
		'{OP_CMP,   8'hFF, 1'b1, 1'b1, '{1'b1, 1'b0, 7'd100, 14'd1, 14'd1}},
		'{OP_TICK,  8'h00, 1'b0, 1'b0, '0},
		'{OP_TICK,  8'hFF, 1'b1, 1'b0, '0}
	};

	// Directed words with every register at zero.
	stim_row_t zero_rows [$] = '{
		'{OP_REF,   8'h80, 1'b0, 1'b0, '0},
		'{OP_REF,   8'h00, 1'b1, 1'b0, '0},
		'{OP_CMP,   8'h80, 1'b0, 1'b0, '0},
		'{OP_CMP,   8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 7'd0,   14'd0, 14'd2}},
		'{OP_CMP,   8'h7F, 1'b0, 1'b0, '0},
		'{OP_CMP,   8'hFF, 1'b0, 1'b0, '0},
		'{OP_CMP,   8'h00, 1'b1, 1'b1, '{1'b1, 1'b1, 7'd100, 14'd2, 14'd2}},
		'{OP_TICK,  8'h55, 1'b0, 1'b0, '0},
		'{OP_CMP,   8'h80, 1'b1, 1'b1, '{1'b1, 1'b1, 7'd0,   14'd0, 14'd1}},
		'{OP_REF,   8'h01, 1'b0, 1'b0, '0},
		'{OP_CMP,   8'h01, 1'b0, 1'b0, '0},
		'{OP_REF,   8'h02, 1'b1, 1'b0, '0},
		'{OP_CMP,   8'h05, 1'b1, 1'b0, '0}
	};

	// Applies one accepted word to the predicted state; returns 1 when it yields a report.
	function automatic bit judge_word(input logic [1:0] op, input logic [7:0] b,
			input logic last, output detection_t rep);
		int unsigned span, kept, gap, pct;
		bit hit;
		rep = '0;
		if (op == OP_TICK) begin
			if (cooling && cool_secs < 32'hFFFF)
				cool_secs++;
			return 1'b0;
		end
		if (op != OP_REF && op != OP_CMP)
			return 1'b0;
		if (op == OP_REF && new_ref) begin
			kept_count = 0;
			stride_pos = 0;
			cmp_count  = 0;
			diff_count = 0;
			new_ref    = 1'b0;
		end
		// A zero stride behaves as a stride of one.
		span = (stride_cfg == 8'd0) ? 1 : int'(stride_cfg);
		hit = (stride_pos == 0);
		stride_pos = (stride_pos + 1 >= span) ? 0 : stride_pos + 1;
		if (op == OP_REF) begin
			if (hit && kept_count < MAX_SAMPLES) begin
				kept_samples[kept_count] = b;
				kept_count++;
			end
			if (last) begin
				stride_pos = 0;
				new_ref    = 1'b1;
			end
			return 1'b0;
		end
		if (hit && cmp_count < kept_count) begin
			kept = int'(kept_samples[cmp_count]);
			gap = (kept > int'(b)) ? kept - int'(b) : int'(b) - kept;
			if (gap > int'(delta_cfg))
				diff_count++;
			cmp_count++;
		end
		if (!last)
			return 1'b0;
		pct = (cmp_count != 0) ? (diff_count * 100) / cmp_count : 0;
		rep.motion  = (pct >= int'(thr_cfg));
		rep.trigger = rep.motion && !cooling;
		if (rep.trigger) begin
			cooling   = 1'b1;
			cool_secs = 0;
		end
		// The cooldown check comes after any trigger of this frame.
		if (cooling && cool_secs >= int'(cool_cfg))
			cooling = 1'b0;
		rep.percent  = 7'(pct);
		rep.changed  = 14'(diff_count);
		rep.compared = 14'(cmp_count);
		stride_pos = 0;
		cmp_count  = 0;
		diff_count = 0;
		return 1'b1;
	endfunction

	// Moves a byte away from its reference, by more than the difference limit when big is set, clamped to 0..255.
	function automatic logic [7:0] nudge(input logic [7:0] base, input bit big);
		int d, v;
		d = big ? int'(delta_cfg) + 1 + int'($urandom_range(0, 15))
			: int'($urandom_range(0, int'(delta_cfg)));
		v = ($urandom_range(0, 1) == 0) ? int'(base) + d : int'(base) - d;
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		bad_fields++;
		if (bad_fields <= 100)
			$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	task automatic set_pacing(input int mode);
		case (mode)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 81; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 81; end
			default: begin send_gap_pct = 24; stall_pct = 24; end
		endcase
	endtask

	// Offers one word, waits for its acceptance and records what it should yield.
	task automatic send_word(input logic [1:0] op, input logic [7:0] data, input logic last,
			input logic typed = 1'b0, input detection_t want = '0);
		detection_t rep;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.data_byte <= data;
		in_ch.last_byte <= last;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		if (op != OP_SPARE)
			items_sent++;
		if (judge_word(op, data, last, rep))
			pending_reports.push_back(typed ? want : rep);
	endtask

	task automatic walk_rows(input stim_row_t rows [$]);
		foreach (rows[i])
			send_word(rows[i].op, rows[i].data, rows[i].last, rows[i].typed, rows[i].want);
	endtask

	// Stops offering words until every report is out and the block has settled.
	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers while the block is idle.
	task automatic configure(input logic [7:0] stride_v, input logic [7:0] delta_v,
			input logic [6:0] thr_v, input logic [15:0] cool_v);
		logic [1:0]  reg_ids [4];
		logic [15:0] reg_vals [4];
		reg_ids  = '{CFG_SAMPLE_STEP, CFG_DIFF_LIMIT, CFG_THRESHOLD, CFG_COOLDOWN};
		reg_vals = '{{8'd0, stride_v}, {8'd0, delta_v}, {9'd0, thr_v}, cool_v};
		wait_drain();
		for (int r = 0; r < 4; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_ids[r];
			cfg_data  <= reg_vals[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		stride_cfg = stride_v;
		delta_cfg  = delta_v;
		thr_cfg    = thr_v;
		cool_cfg   = cool_v;
	endtask

	// One reference frame followed by comparison frames close to it, with ticks mixed in.
	task automatic send_frame_set(input int ref_len, input int frames);
		logic [7:0] ref_bytes [$];
		logic [7:0] b;
		int cmp_len, change_pct;
		for (int i = 0; i < ref_len; i++) begin
			b = 8'($urandom);
			ref_bytes.push_back(b);
			send_word(OP_REF, b, i == ref_len - 1);
		end
		repeat (frames) begin
			cmp_len = ref_len + int'($urandom_range(0, 4)) - 2;
			if (cmp_len < 1)
				cmp_len = 1;
			change_pct = $urandom_range(0, 100);
			for (int j = 0; j < cmp_len; j++) begin
				if ($urandom_range(0, 19) == 0)
					send_word(OP_TICK, 8'($urandom), 1'($urandom));
				if (j >= ref_len || $urandom_range(0, 7) == 0)
					b = 8'($urandom);
				else
					b = nudge(ref_bytes[j], $urandom_range(0, 99) < change_pct);
				send_word(OP_CMP, b, j == cmp_len - 1);
			end
			repeat ($urandom_range(0, 2)) send_word(OP_TICK, 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off on request.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Each accepted report is checked against the oldest prediction.
	always @(posedge clk) begin
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("report with none pending", 1, 0);
			end else begin
				oldest_report = pending_reports.pop_front();
				if (out_ch.motion !== oldest_report.motion)
					flag_mismatch("motion", out_ch.motion, oldest_report.motion);
				if (out_ch.trigger !== oldest_report.trigger)
					flag_mismatch("trigger", out_ch.trigger, oldest_report.trigger);
				if (out_ch.percent !== oldest_report.percent)
					flag_mismatch("percent", out_ch.percent, oldest_report.percent);
				if (out_ch.changed_count !== oldest_report.changed)
					flag_mismatch("changed_count", out_ch.changed_count,
						oldest_report.changed);
				if (out_ch.compared_count !== oldest_report.compared)
					flag_mismatch("compared_count", out_ch.compared_count,
						oldest_report.compared);
			end
		end
	end

	// The run ends if no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_no, phase_start, random_start;
		int ref_len;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_SAMPLE_STEP;
		cfg_data        <= 16'd0;
		in_ch.valid     <= 1'b0;
		in_ch.opcode    <= OP_REF;
		in_ch.data_byte <= 8'd0;
		in_ch.last_byte <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: reset values first, then all registers at zero.
		set_pacing(3);
		walk_rows(reset_rows);
		configure(8'd0, 8'd0, 7'd0, 16'd0);
		walk_rows(zero_rows);

		// Hold the receiver off while short frames pile up, then let it all drain.
		configure(8'd4, 8'd30, 7'd50, 16'd2);
		set_pacing(0);
		hold_req = 1'b1;
		send_frame_set(1, 8);
		wait_drain();

		// Random phases, each with its own registers and pacing.
		phase_no     = 0;
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			case (phase_no)
				0: configure(8'd1, 8'd0, 7'd0, 16'd0);
				1: configure(8'd255, 8'd255, 7'd100, 16'hFFFF);
				2: configure(8'd0, 8'd20, 7'd127, 16'd3);
				3: configure(8'd2, 8'd255, 7'd0, 16'd1);
				default: configure(8'($urandom_range(1, 6)), 8'($urandom),
					7'($urandom_range(0, 100)), 16'($urandom_range(0, 4)));
			endcase
			set_pacing(phase_no % 4);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					// Noise: stray words of any opcode, partial frames included.
					repeat ($urandom_range(1, 6))
						send_word(2'($urandom_range(0, 3)), 8'($urandom),
							1'($urandom_range(0, 3) == 0));
				end else begin
					ref_len = ($urandom_range(0, 39) == 0) ? $urandom_range(30, 60)
						: $urandom_range(1, 16);
					send_frame_set(ref_len, $urandom_range(1, 3));
				end
			end
			phase_no++;
		end

		wait_drain();
		if (bad_fields == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
